// ===== hw/rtl/bcomp_pkg.sv =====
// Shared constants and types for the barometric pressure compensation block.
`default_nettype none

package bcomp_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CFG_W = 64;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
	localparam logic signed [31:0] B4_OFFSET = 32'sd32768;
	localparam logic signed [31:0] P_COEF_SQ = 32'sd3038;
	localparam logic signed [31:0] P_COEF_LIN = -32'sd7357;
	localparam logic signed [31:0] P_COEF_OFS = 32'sd3791;
	localparam logic [15:0] B7_SCALE = 16'd50000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAL_FIRST = 2'd0,
		CFG_CAL_SECOND = 2'd1,
		CFG_CAL_THIRD = 2'd2,
		CFG_OVERSAMPLING = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bcomp_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage, with sideband.
`default_nettype none

module bcomp_div #(
	parameter int unsigned W = bcomp_pkg::DATA_W,
	parameter int unsigned SBW = 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_vld,
	input wire logic [W-1:0] dividend,
	input wire logic [W-1:0] divisor,
	input wire logic [SBW-1:0] in_sb,
	output logic out_vld,
	output logic [W-1:0] quotient,
	output logic [SBW-1:0] out_sb
);

	logic [W-1:0] rem_s [0:W-1];
	logic [W-1:0] dq_s [0:W-1];
	logic [W-1:0] dvs_s [0:W-1];
	logic [SBW-1:0] sb_s [0:W-1];
	logic vld_s [0:W-1];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W-1:0] r_in;
		logic [W-1:0] d_in;
		logic [W-1:0] v_in;
		logic [SBW-1:0] sb_in;
		logic vld_in;
		logic [W:0] trial;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign d_in = dividend;
			assign v_in = divisor;
			assign sb_in = in_sb;
			assign vld_in = in_vld;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign d_in = dq_s[k-1];
			assign v_in = dvs_s[k-1];
			assign sb_in = sb_s[k-1];
			assign vld_in = vld_s[k-1];
		end

		// borrow in the top bit means the divisor does not fit
		assign trial = {r_in, d_in[W-1]} - {1'b0, v_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (trial[W]) begin
					rem_s[k] <= {r_in[W-2:0], d_in[W-1]};
				end else begin
					rem_s[k] <= trial[W-1:0];
				end
				dq_s[k] <= {d_in[W-2:0], ~trial[W]};
				dvs_s[k] <= v_in;
				sb_s[k] <= sb_in;
			end
		end
	end

	assign out_vld = vld_s[W-1];
	assign quotient = dq_s[W-1];
	assign out_sb = sb_s[W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/barometric_pressure_compensation.sv =====
// Barometric pressure compensation: raw temperature/pressure to 0.1 C and pascals.
//
// Input channel: in_valid/in_stall with raw_temperature and raw_pressure; a
// transaction takes place when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with temperature_tenths, pressure_pa and
// divide_error; one result transaction per input transaction, in order.
// Calibration words and oversampling are written through cfg_write, cfg_index
// and cfg_data; the user must do so only while no item is in flight, as the block does not enforce it.
// Throughput: one item per cycle unless the output stalls. The path from
// input to output register holds two 32-stage bit-per-stage dividers
// (temperature and pressure) plus 14 arithmetic stages, each at most one multiplier deep.
// The whole pipeline advances together; when the output holds a result and
// out_stall is high, every stage freezes and in_stall is raised, so nothing
// is lost or repeated. Reset clears all valid bits and sets the calibration
// words to zero and oversampling to 3.
// A zero divisor in either division gives divide_error with both results 0.
`default_nettype none

module barometric_pressure_compensation (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [bcomp_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [bcomp_pkg::CFG_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [15:0] raw_temperature,
	input wire logic [18:0] raw_pressure,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] temperature_tenths,
	output logic signed [31:0] pressure_pa,
	output logic divide_error
);

	localparam int unsigned DW = bcomp_pkg::DATA_W;
	localparam int unsigned SBA_W = 2 + DW + 19;
	localparam int unsigned SBB_W = 2 + DW;

	// configuration
	logic [63:0] cal1_q;
	logic [63:0] cal2_q;
	logic [31:0] cal3_q;
	logic [1:0] oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal1_q <= '0;
			cal2_q <= '0;
			cal3_q <= '0;
			oss_q <= 2'd3;
		end else if (cfg_write) begin
			case (bcomp_pkg::cfg_reg_t'(cfg_index))
				bcomp_pkg::CFG_CAL_FIRST: cal1_q <= cfg_data;
				bcomp_pkg::CFG_CAL_SECOND: cal2_q <= cfg_data;
				bcomp_pkg::CFG_CAL_THIRD: cal3_q <= cfg_data[31:0];
				bcomp_pkg::CFG_OVERSAMPLING: oss_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic signed [31:0] ac1w, ac2w, ac3w, ac4w, b1w, b2w, mdw;
	logic signed [15:0] mc;
	logic [15:0] ac5, ac6;

	assign ac1w = 32'($signed(cal1_q[63:48]));
	assign ac2w = 32'($signed(cal1_q[47:32]));
	assign ac3w = 32'($signed(cal1_q[31:16]));
	assign ac4w = $signed({16'b0, cal1_q[15:0]});
	assign ac5 = cal2_q[63:48];
	assign ac6 = cal2_q[47:32];
	assign b1w = 32'($signed(cal2_q[31:16]));
	assign b2w = 32'($signed(cal2_q[15:0]));
	assign mc = $signed(cal3_q[31:16]);
	assign mdw = 32'($signed(cal3_q[15:0]));

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s12, v_s13, v_s14, v_s15;
	logic va, vb;

	// s1: X1 of temperature
	logic signed [16:0] utd;
	logic signed [33:0] tprod;
	logic signed [31:0] x1_s1;
	logic [18:0] up_s1;

	assign utd = $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
	assign tprod = utd * $signed({1'b0, ac5});

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= $signed(tprod[31:0]) >>> 15;
			up_s1 <= raw_pressure;
		end
	end

	// s2: magnitudes for the signed temperature division
	logic signed [31:0] den, numx;
	logic [31:0] dvd_s2, dvs_s2;
	logic neg_s2, dz_s2;
	logic signed [31:0] x1_s2;
	logic [18:0] up_s2;

	assign den = x1_s1 + mdw;
	assign numx = {{5{mc[15]}}, mc, 11'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s2 <= mc[15] ? $unsigned(-numx) : $unsigned(numx);
			dvs_s2 <= den[31] ? $unsigned(-den) : $unsigned(den);
			neg_s2 <= mc[15] ^ den[31];
			dz_s2 <= (den == '0);
			x1_s2 <= x1_s1;
			up_s2 <= up_s1;
		end
	end

	logic [DW-1:0] qa;
	logic [SBA_W-1:0] sba;

	bcomp_div #(
		.W(DW),
		.SBW(SBA_W)
	) u_div_t (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_vld(v_s2),
		.dividend(dvd_s2),
		.divisor(dvs_s2),
		.in_sb({neg_s2, dz_s2, x1_s2, up_s2}),
		.out_vld(va),
		.quotient(qa),
		.out_sb(sba)
	);

	logic a_neg, a_dz;
	logic signed [31:0] a_x1;
	logic [18:0] a_up;
	assign {a_neg, a_dz, a_x1, a_up} = sba;

	// s3: B5
	logic signed [31:0] b5_s3;
	logic dz_s3;
	logic [18:0] up_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			b5_s3 <= a_x1 + (a_neg ? -$signed(qa) : $signed(qa));
			dz_s3 <= a_dz;
			up_s3 <= a_up;
		end
	end

	// s4: B6 and temperature
	logic signed [31:0] b6_s4, temp_s4;
	logic dz_s4;
	logic [18:0] up_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			b6_s4 <= b5_s3 - bcomp_pkg::B6_OFFSET;
			temp_s4 <= (b5_s3 + 32'sd8) >>> 4;
			dz_s4 <= dz_s3;
			up_s4 <= up_s3;
		end
	end

	// s5: products of B6
	logic signed [31:0] m_sq, m_x2a, m_x1b;
	logic signed [31:0] sq_s5, x2a_s5, x1b_s5, temp_s5;
	logic dz_s5;
	logic [18:0] up_s5;

	assign m_sq = b6_s4 * b6_s4;
	assign m_x2a = ac2w * b6_s4;
	assign m_x1b = ac3w * b6_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s5 <= m_sq >>> 12;
			x2a_s5 <= m_x2a >>> 11;
			x1b_s5 <= m_x1b >>> 13;
			temp_s5 <= temp_s4;
			dz_s5 <= dz_s4;
			up_s5 <= up_s4;
		end
	end

	// s6: products of the squared term
	logic signed [31:0] m_x1a, m_x2b;
	logic signed [31:0] x1a_s6, x2b_s6, x2a_s6, x1b_s6, temp_s6;
	logic dz_s6;
	logic [18:0] up_s6;

	assign m_x1a = b2w * sq_s5;
	assign m_x2b = b1w * sq_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			x1a_s6 <= m_x1a >>> 11;
			x2b_s6 <= m_x2b >>> 16;
			x2a_s6 <= x2a_s5;
			x1b_s6 <= x1b_s5;
			temp_s6 <= temp_s5;
			dz_s6 <= dz_s5;
			up_s6 <= up_s5;
		end
	end

	// s7
	logic signed [31:0] x3a_s7, x3b_s7, temp_s7;
	logic dz_s7;
	logic [18:0] up_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			x3a_s7 <= (ac1w <<< 2) + x1a_s6 + x2a_s6;
			x3b_s7 <= (x1b_s6 + x2b_s6 + 32'sd2) >>> 2;
			temp_s7 <= temp_s6;
			dz_s7 <= dz_s6;
			up_s7 <= up_s6;
		end
	end

	// s8: B3
	logic signed [31:0] b3_s8, bf_s8, temp_s8;
	logic dz_s8;
	logic [18:0] up_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			b3_s8 <= ((x3a_s7 <<< oss_q) + 32'sd2) >>> 2;
			bf_s8 <= x3b_s7 + bcomp_pkg::B4_OFFSET;
			temp_s8 <= temp_s7;
			dz_s8 <= dz_s7;
			up_s8 <= up_s7;
		end
	end

	// s9: B4
	logic [31:0] m_b4;
	logic [31:0] b4_s9;
	logic signed [31:0] diff_s9, temp_s9;
	logic dz_s9;

	assign m_b4 = $unsigned(ac4w) * $unsigned(bf_s8);

	always_ff @(posedge clk) begin
		if (adv) begin
			b4_s9 <= m_b4 >> 15;
			diff_s9 <= $signed({13'b0, up_s8}) - b3_s8;
			temp_s9 <= temp_s8;
			dz_s9 <= dz_s8;
		end
	end

	// s10: B7
	logic [15:0] scl;
	logic [31:0] m_b7;
	logic [31:0] b7_s10, b4_s10;
	logic signed [31:0] temp_s10;
	logic err_s10;

	assign scl = bcomp_pkg::B7_SCALE >> oss_q;
	assign m_b7 = $unsigned(diff_s9) * {16'b0, scl};

	always_ff @(posedge clk) begin
		if (adv) begin
			b7_s10 <= m_b7;
			b4_s10 <= b4_s9;
			temp_s10 <= temp_s9;
			err_s10 <= dz_s9 || (b4_s9 == '0);
		end
	end

	// overflow-safe branch: shift before the divide only while B7 has headroom
	logic hi;
	logic [DW-1:0] qb;
	logic [SBB_W-1:0] sbb;

	assign hi = b7_s10[31];

	bcomp_div #(
		.W(DW),
		.SBW(SBB_W)
	) u_div_p (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_vld(v_s10),
		.dividend(hi ? b7_s10 : {b7_s10[30:0], 1'b0}),
		.divisor(b4_s10),
		.in_sb({hi, err_s10, temp_s10}),
		.out_vld(vb),
		.quotient(qb),
		.out_sb(sbb)
	);

	logic b_hi, b_err;
	logic signed [31:0] b_temp;
	assign {b_hi, b_err, b_temp} = sbb;

	// s12
	logic signed [31:0] p_s12, temp_s12;
	logic err_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s12 <= b_hi ? $signed({qb[30:0], 1'b0}) : $signed(qb);
			temp_s12 <= b_temp;
			err_s12 <= b_err;
		end
	end

	// s13
	logic signed [31:0] q8, m_qq, m_x2c;
	logic signed [31:0] qq_s13, x2c_s13, p_s13, temp_s13;
	logic err_s13;

	assign q8 = p_s12 >>> 8;
	assign m_qq = q8 * q8;
	assign m_x2c = p_s12 * bcomp_pkg::P_COEF_LIN;

	always_ff @(posedge clk) begin
		if (adv) begin
			qq_s13 <= m_qq;
			x2c_s13 <= m_x2c >>> 16;
			p_s13 <= p_s12;
			temp_s13 <= temp_s12;
			err_s13 <= err_s12;
		end
	end

	// s14
	logic signed [31:0] m_x1c;
	logic signed [31:0] x1c_s14, x2c_s14, p_s14, temp_s14;
	logic err_s14;

	assign m_x1c = qq_s13 * bcomp_pkg::P_COEF_SQ;

	always_ff @(posedge clk) begin
		if (adv) begin
			x1c_s14 <= m_x1c >>> 16;
			x2c_s14 <= x2c_s13;
			p_s14 <= p_s13;
			temp_s14 <= temp_s13;
			err_s14 <= err_s13;
		end
	end

	// s15: output register
	logic signed [31:0] pfin;
	assign pfin = p_s14 + ((x1c_s14 + x2c_s14 + bcomp_pkg::P_COEF_OFS) >>> 4);

	always_ff @(posedge clk) begin
		if (adv) begin
			temperature_tenths <= err_s14 ? '0 : temp_s14;
			pressure_pa <= err_s14 ? '0 : pfin;
			divide_error <= err_s14;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= va;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s12 <= vb;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	assign out_valid = v_s15;

	// a failed division always reports zero results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_error) |-> (temperature_tenths == '0 && pressure_pa == '0))
		else $error("divide_error with nonzero results");

	// a frozen pipeline keeps its internal stages
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> ($stable(v_s1) && $stable(v_s10) && $stable(v_s14)))
		else $error("pipeline moved during stall");

	// a new result only appears after the pipeline advanced
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(adv && v_s14))
		else $error("result appeared without an advancing stage");

endmodule

`default_nettype wire
